@@ rtl/assert_macros.svh @@
// Assertion macros shared by the lru stack distance RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check an expression at every clock edge outside reset.
`define LSD_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
// Check that an antecedent implies a consequent at the same edge.
`define LSD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// Check that an antecedent implies a consequent at the next edge.
`define LSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LSD_ASSERT_ALWAYS(lbl, expr, msg)
`define LSD_ASSERT_IMPL(lbl, ante, cons, msg)
`define LSD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/lsd_pkg.sv @@
// Package with sizes, types and helpers of the lru stack distance block.
`timescale 1ns / 1ps
package lsd_pkg;
	localparam int MAX_ENTRIES = 64;
	localparam int PAGE_BITS = 20;
	localparam int IN_PAGE_W = 20;
	localparam int CAP_W = 7;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
	localparam int DEPTH_W = 6;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int DEPTH_CALC_W = (CNT_W > DEPTH_W) ? CNT_W : DEPTH_W;
	localparam int DEPTH_MAX = (1 << DEPTH_W) - 1;

	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [CNT_W-1:0] count_t;

	// Per-cell control from the top level
	typedef struct packed {
		logic accept;
		logic valid;
	} cell_ctl_t;

	// Clamp the capacity register to 1 .. MAX_ENTRIES
	function automatic count_t eff_cap(input logic [CAP_W-1:0] cap);
		int c;
		c = int'(cap);
		if (c == 0) c = 1;
		if (c > MAX_ENTRIES) c = MAX_ENTRIES;
		return count_t'(c);
	endfunction
endpackage

@@ rtl/lsd_intf.sv @@
// Channel interfaces of the lru stack distance block.
`timescale 1ns / 1ps
interface lsd_page_if;
	logic valid;
	logic ready;
	logic [lsd_pkg::IN_PAGE_W-1:0] page_number;
	modport source (output valid, output page_number, input ready);
	modport sink (input valid, input page_number, output ready);
endinterface

interface lsd_res_if;
	logic valid;
	logic ready;
	logic hit;
	logic [lsd_pkg::DEPTH_W-1:0] stack_depth;
	modport source (output valid, output hit, output stack_depth, input ready);
	modport sink (input valid, input hit, input stack_depth, output ready);
endinterface

interface lsd_cfg_if;
	logic valid;
	logic ready;
	logic [lsd_pkg::CAP_W-1:0] capacity;
	modport source (output valid, output capacity, input ready);
	modport sink (input valid, input capacity, output ready);
endinterface

@@ rtl/lsd_cell.sv @@
// One entry of the recency stack: holds a page, compares it, shifts from its neighbor.
`timescale 1ns / 1ps
module lsd_cell (
	input  logic              clk,
	input  lsd_pkg::cell_ctl_t ctl,
	input  lsd_pkg::page_t    key,
	input  lsd_pkg::page_t    nb_page,
	input  logic              found_in,
	output logic              found_out,
	output logic              first_hit,
	output lsd_pkg::page_t    page
);
	import lsd_pkg::*;

	page_t page_q;
	logic  match;

	// Compare the stored page against the incoming item
	assign match = ctl.valid && (page_q == key);
	assign first_hit = match && !found_in;
	assign found_out = found_in || match;
	assign page = page_q;

	// Advance from the neighbor while no hit lies closer to the top
	always_ff @(posedge clk) begin
		if (ctl.accept && !found_in) begin
			page_q <= nb_page;
		end
	end
endmodule

@@ rtl/lru_stack_distance.sv @@
// Top level of the lru stack distance block: cell chain, count and result register.
`timescale 1ns / 1ps
// Usage:
//   req carries one page reference per item (page_number). rsp returns one
//   result per item: hit, and stack_depth (0 = most recently used) on a hit,
//   0 on a miss. cfg writes the capacity register (1..64, 0 acts as 1, larger
//   values act as 64); lowering it drops the least recent pages at once.
// Latency: the result is registered and appears the cycle after the item is
//   accepted.
// Throughput: one item per cycle unless stalled. Every cell compares its page with
//   the item in parallel; the hit flag ripples down the cell chain and the cells
//   above the hit (all of them on a miss) shift down by one in the same cycle.
// Reset: the stack is empty (count 0) and capacity is 64. Cell contents need
//   no clearing; the count marks which cells hold pages.
// Stall: while rsp holds a result that is not taken, req.ready stays low and
//   the result holds. cfg is always ready.
`include "assert_macros.svh"
module lru_stack_distance (
	input logic clk,
	input logic arst_n,
	lsd_page_if.sink req,
	lsd_res_if.source rsp,
	lsd_cfg_if.sink cfg
);
	import lsd_pkg::*;

	logic [CAP_W-1:0] cap_q;
	count_t count_q;
	count_t count_d;
	count_t cap_eff;
	count_t cap_new;
	logic out_valid_q;
	logic hit_q;
	logic [DEPTH_W-1:0] depth_q;
	logic acc;
	logic cfg_we;
	logic miss_grow;
	page_t key;
	page_t cell_page [MAX_ENTRIES];
	logic [MAX_ENTRIES:0] found;
	logic [MAX_ENTRIES-1:0] first_hit;
	logic any_hit;
	logic [DEPTH_CALC_W-1:0] depth_full;
	logic [DEPTH_W-1:0] depth_sat;

	// Handshakes
	assign req.ready = !out_valid_q || rsp.ready;
	assign acc = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign cfg_we = cfg.valid;
	assign key = req.page_number[PAGE_BITS-1:0];
	assign cap_eff = eff_cap(cap_q);
	assign cap_new = eff_cap(cfg.capacity);

	// Chain of cells, top of stack at cell 0
	assign found[0] = 1'b0;
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		cell_ctl_t ctl;
		page_t nb_page;
		assign ctl.accept = acc;
		assign ctl.valid = count_t'(i) < count_q;
		if (i == 0) begin : g_top
			assign nb_page = key;
		end else begin : g_rest
			assign nb_page = cell_page[i-1];
		end
		lsd_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.key       (key),
			.nb_page   (nb_page),
			.found_in  (found[i]),
			.found_out (found[i+1]),
			.first_hit (first_hit[i]),
			.page      (cell_page[i])
		);
	end
	assign any_hit = found[MAX_ENTRIES];

	// Encode the position of the first hit
	always_comb begin
		depth_full = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (first_hit[i]) depth_full = depth_full | DEPTH_CALC_W'(i);
		end
		if (depth_full > DEPTH_CALC_W'(DEPTH_MAX)) depth_sat = DEPTH_W'(DEPTH_MAX);
		else depth_sat = depth_full[DEPTH_W-1:0];
	end

	// Grow the stack on a miss while below capacity and no capacity write is made
	assign miss_grow = acc && !any_hit && !cfg_we && (count_q < cap_eff);

	// Next fill count: clamp on a capacity write, grow on a miss
	always_comb begin
		count_d = count_q;
		if (cfg_we) begin
			if (count_q > cap_new) count_d = cap_new;
		end else if (miss_grow) begin
			count_d = count_q + count_t'(1);
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) cap_q <= cfg.capacity;
			count_q <= count_d;
			if (acc) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// Result payload, held while the receiver stalls
	always_ff @(posedge clk) begin
		if (acc) begin
			hit_q <= any_hit;
			depth_q <= any_hit ? depth_sat : '0;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.hit = hit_q;
	assign rsp.stack_depth = depth_q;

	// Checks
	`LSD_ASSERT_ALWAYS(a_count_cap, count_q <= cap_eff, "fill count above capacity")
	`LSD_ASSERT_ALWAYS(a_one_hit, $onehot0(first_hit), "more than one first hit")
	`LSD_ASSERT_IMPL(a_miss_depth, rsp.valid && !rsp.hit, rsp.stack_depth == '0, "miss with depth")
	`LSD_ASSERT_NEXT(a_miss_grow, miss_grow, count_q == $past(count_q) + count_t'(1), "stack did not grow")
endmodule
